// ===== sv/rnhc_pkg.sv =====
// ----------------------------------------------------------------------------
// rnhc_pkg
// Shared word types and codes for the nearest-hit ray caster.
// ----------------------------------------------------------------------------
package rnhc_pkg;

    // command word: one load or one cast
    typedef struct packed {
        logic [1:0]         opcode;
        logic [6:0]         slot;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
        logic signed [31:0] operand_c;
        logic signed [31:0] operand_d;
        logic signed [31:0] operand_e;
        logic signed [31:0] operand_f;
    } cmd_t;

    // result word
    typedef struct packed {
        logic [30:0] hit_distance;
        logic        hit_found;
        logic [1:0]  hit_kind;
    } result_t;

    localparam int QUOT_W = 31;
    localparam logic [QUOT_W-1:0] SAT31 = '1;

    localparam logic [1:0] OP_LOAD_WALL = 2'd0;
    localparam logic [1:0] OP_LOAD_FACE = 2'd1;
    localparam logic [1:0] OP_CAST      = 2'd2;
    localparam logic [1:0] OP_UNUSED    = 2'd3;

    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_WALL   = 2'd1;
    localparam logic [1:0] KIND_FACE   = 2'd2;
    localparam logic [1:0] KIND_GROUND = 2'd3;

    localparam logic [1:0] CFG_SEGMENT_COUNT = 2'd0;
    localparam logic [1:0] CFG_FACE_COUNT    = 2'd1;
    localparam logic [1:0] CFG_MIN_RANGE     = 2'd2;
    localparam logic [1:0] CFG_MAX_RANGE     = 2'd3;

endpackage

// ===== sv/rnhc_div.sv =====
// ----------------------------------------------------------------------------
// rnhc_div
// Saturating fixed-point divider, floor(num * 2^FRAC_BITS / den), one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module rnhc_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [63:0]                     num,
    input  logic [63:0]                     den,
    output logic                            done,
    output logic [rnhc_pkg::QUOT_W-1:0]     quot
);

    localparam int QW = rnhc_pkg::QUOT_W;
    localparam int PRE_SHIFT = QW - FRAC_BITS;

    logic              run_reg;
    logic              done_reg;
    logic [4:0]        cnt_reg;
    logic [63:0]       r_reg;
    logic [QW-1:0]     lo_reg;
    logic [QW-1:0]     q_reg;
    logic [63:0]       d_reg;

    logic              sat;
    logic [64:0]       r_shift;
    logic              r_ge;

    // quotient does not fit in 31 bits
    assign sat = (den == 64'd0) || (96'(num) >= (96'(den) << PRE_SHIFT));
    assign r_shift = {r_reg, lo_reg[QW-1]};
    assign r_ge = r_shift >= {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            r_reg    <= '0;
            lo_reg   <= '0;
            q_reg    <= '0;
            d_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                d_reg <= den;
                if (sat)
                begin
                    q_reg    <= rnhc_pkg::SAT31;
                    done_reg <= 1'b1;
                    run_reg  <= 1'b0;
                end
                else
                begin
                    q_reg   <= '0;
                    r_reg   <= num >> PRE_SHIFT;
                    lo_reg  <= QW'(96'(num) << FRAC_BITS);
                    cnt_reg <= 5'(QW);
                    run_reg <= 1'b1;
                end
            end
            else if (run_reg)
            begin
                lo_reg <= {lo_reg[QW-2:0], 1'b0};
                if (r_ge)
                begin
                    r_reg <= 64'(r_shift - {1'b0, d_reg});
                    q_reg <= {q_reg[QW-2:0], 1'b1};
                end
                else
                begin
                    r_reg <= r_shift[63:0];
                    q_reg <= {q_reg[QW-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// ===== sv/ray_nearest_hit_caster_top.sv =====
// ----------------------------------------------------------------------------
// ray_nearest_hit_caster_top
// Nearest-hit ray caster over wall-segment and box top-face tables and the ground plane.
//
// channel   direction  handshake                 word
// command   in         start & !busy             cmd (cmd_t)
// result    out        result_valid, one cycle   result (result_t)
// config    in         cfg_valid & cfg_ready     cfg_index, cfg_data
//
// a load leaves busy low; a cast holds busy high.
// a wall that fails the crossing test skips the divide; faces are tested for a
// rising ray only, and a face below the origin skips the divide; the ground test
// follows; each quotient comes from the shared bit-serial divider, and one shared
// 33x33 multiplier serves all products.
// reset does not touch the tables: table contents are undefined until loaded.
// the receiver cannot stall: a result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module ray_nearest_hit_caster_top #(
    parameter int MAX_WALLS = 128,
    parameter int MAX_FACES = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  rnhc_pkg::cmd_t      cmd,
    output logic                result_valid,
    output rnhc_pkg::result_t   result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    localparam int WAW = $clog2(MAX_WALLS);
    localparam int WCW = $clog2(MAX_WALLS + 1);
    localparam int FAW = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
    localparam int FCW = $clog2(MAX_FACES + 1);

    typedef struct packed {
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic signed [31:0] d;
        logic signed [31:0] e;
    } entry_t;

    typedef enum logic [4:0] {
        S_IDLE, S_WSEL, S_WREAD, S_WMUL, S_WSUM, S_WCHK, S_WDIV, S_WZMUL, S_WZ,
        S_WNEXT, S_FSEL, S_FREAD, S_FDIV, S_FMULX, S_FMULY, S_FTEST, S_FNEXT,
        S_GND, S_GDIV, S_DONE
    } state_t;

    function automatic logic signed [31:0] clamp_sym(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v > 33'sh0_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -33'sh0_7FFF_FFFF)
            r = -32'sh7FFF_FFFF;
        else
            r = 32'(v);
        return r;
    endfunction

    // configuration registers
    logic [7:0]  segment_count_reg;
    logic [5:0]  face_count_reg;
    logic [30:0] range_lo_reg;
    logic [30:0] max_range_reg;

    // tables
    entry_t wall_mem [MAX_WALLS];
    entry_t face_mem [MAX_FACES];
    entry_t wall_rd_reg;
    entry_t face_rd_reg;

    state_t             state_reg;
    logic               busy_reg;
    logic               result_valid_reg;
    rnhc_pkg::result_t  result_reg;
    logic [WCW-1:0]     widx_reg;
    logic [FCW-1:0]     fidx_reg;
    logic [2:0]         mstep_reg;
    logic signed [31:0] ox_reg, oy_reg, oz_reg, dx_reg, dy_reg, dz_reg;
    logic signed [31:0] cdx_reg, cdy_reg;
    logic signed [31:0] ex_reg, ey_reg, fx_reg, fy_reg, wh_reg;
    logic signed [31:0] fcx_reg, fcy_reg, fhx_reg, fhy_reg;
    logic signed [63:0] p_reg [6];
    logic signed [63:0] den_reg, tn_reg, un_reg;
    logic [30:0]        t_reg;
    logic [30:0]        best_reg;
    logic [1:0]         kind_reg;
    logic signed [65:0] mul_reg;
    logic signed [65:0] hx_reg;

    // combinational helpers
    logic               accept;
    logic               wall_we;
    logic               face_we;
    logic [WCW-1:0]     nw;
    logic [FCW-1:0]     nf;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_prod;
    logic signed [31:0] ex_w, ey_w, fx_w, fy_w;
    logic signed [63:0] dabs, tabs, uabs;
    logic               wall_reject;
    logic signed [65:0] zq, hlim;
    logic signed [32:0] fnum;
    logic signed [32:0] ocx, ocy, gden;
    logic signed [65:0] hx_w, hy_w, hx_abs, hy_abs, hsx_lim, hsy_lim;
    logic               gnd_ok;
    logic               div_start;
    logic [63:0]        div_num, div_den;
    logic               div_done;
    logic [30:0]        div_quot;
    logic [2:0]         pidx;

    assign accept    = start && !busy_reg;
    assign wall_we   = accept && (cmd.opcode == rnhc_pkg::OP_LOAD_WALL)
                       && (32'(cmd.slot) < MAX_WALLS);
    assign face_we   = accept && (cmd.opcode == rnhc_pkg::OP_LOAD_FACE)
                       && (32'(cmd.slot) < MAX_FACES);
    assign cfg_ready = 1'b1;

    assign nw = (32'(segment_count_reg) > MAX_WALLS) ? WCW'(MAX_WALLS)
                                                     : WCW'(segment_count_reg);
    assign nf = (32'(face_count_reg) > MAX_FACES) ? FCW'(MAX_FACES)
                                                  : FCW'(face_count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            segment_count_reg <= 8'd0;
            face_count_reg    <= 6'd0;
            range_lo_reg      <= 31'd26214;
            max_range_reg     <= 31'd9830400;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                rnhc_pkg::CFG_SEGMENT_COUNT: segment_count_reg <= cfg_data[7:0];
                rnhc_pkg::CFG_FACE_COUNT:    face_count_reg    <= cfg_data[5:0];
                rnhc_pkg::CFG_MIN_RANGE:     range_lo_reg      <= cfg_data[30:0];
                rnhc_pkg::CFG_MAX_RANGE:     max_range_reg     <= cfg_data[30:0];
            endcase
        end
    end

    // table memories, registered read
    always_ff @(posedge clk)
    begin
        if (wall_we)
            wall_mem[WAW'(cmd.slot)] <= '{cmd.operand_a, cmd.operand_b, cmd.operand_c,
                                          cmd.operand_d, cmd.operand_e};
        wall_rd_reg <= wall_mem[widx_reg[WAW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (face_we)
            face_mem[FAW'(cmd.slot)] <= '{cmd.operand_a, cmd.operand_b, cmd.operand_c,
                                          cmd.operand_d, cmd.operand_e};
        face_rd_reg <= face_mem[fidx_reg[FAW-1:0]];
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_WMUL:
            begin
                unique case (mstep_reg)
                    3'd0:    begin mul_a = 33'(cdx_reg); mul_b = 33'(ey_reg);  end
                    3'd1:    begin mul_a = 33'(cdy_reg); mul_b = 33'(ex_reg);  end
                    3'd2:    begin mul_a = 33'(fx_reg);  mul_b = 33'(ey_reg);  end
                    3'd3:    begin mul_a = 33'(fy_reg);  mul_b = 33'(ex_reg);  end
                    3'd4:    begin mul_a = 33'(fx_reg);  mul_b = 33'(cdy_reg); end
                    3'd5:    begin mul_a = 33'(fy_reg);  mul_b = 33'(cdx_reg); end
                    default: begin mul_a = '0;           mul_b = '0;           end
                endcase
            end
            S_WZMUL: begin mul_a = $signed({2'b00, t_reg}); mul_b = 33'(dz_reg); end
            S_FMULX: begin mul_a = $signed({2'b00, t_reg}); mul_b = 33'(dx_reg); end
            S_FMULY: begin mul_a = $signed({2'b00, t_reg}); mul_b = 33'(dy_reg); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign mul_prod = mul_a * mul_b;
    assign pidx     = mstep_reg - 3'd1;

    // wall geometry
    assign ex_w = clamp_sym(33'(wall_rd_reg.c) - 33'(wall_rd_reg.a));
    assign ey_w = clamp_sym(33'(wall_rd_reg.d) - 33'(wall_rd_reg.b));
    assign fx_w = clamp_sym(33'(wall_rd_reg.a) - 33'(ox_reg));
    assign fy_w = clamp_sym(33'(wall_rd_reg.b) - 33'(oy_reg));

    assign dabs = den_reg[63] ? -den_reg : den_reg;
    assign tabs = den_reg[63] ? -tn_reg  : tn_reg;
    assign uabs = den_reg[63] ? -un_reg  : un_reg;
    // parallel, behind the origin, or outside the segment
    assign wall_reject = (den_reg == 64'sd0) || tabs[63] || uabs[63] || (uabs > dabs);

    assign zq   = (66'(oz_reg) <<< FRAC_BITS) + mul_reg;
    assign hlim = 66'(wh_reg) <<< FRAC_BITS;

    // face geometry
    assign fnum    = 33'(face_rd_reg.e) - 33'(oz_reg);
    assign ocx     = 33'(ox_reg) - 33'(fcx_reg);
    assign ocy     = 33'(oy_reg) - 33'(fcy_reg);
    assign hx_w    = (66'(ocx) <<< FRAC_BITS) + mul_reg;
    assign hy_w    = (66'(ocy) <<< FRAC_BITS) + mul_reg;
    assign hx_abs  = hx_reg[65] ? -hx_reg : hx_reg;
    assign hy_abs  = hy_w[65] ? -hy_w : hy_w;
    assign hsx_lim = 66'(fhx_reg) <<< FRAC_BITS;
    assign hsy_lim = 66'(fhy_reg) <<< FRAC_BITS;

    // ground plane
    assign gden   = -33'(dz_reg);
    assign gnd_ok = dz_reg[31] && !oz_reg[31];

    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        unique case (state_reg)
            S_WCHK:
            begin
                div_start = !wall_reject;
                div_num   = $unsigned(tabs);
                div_den   = $unsigned(dabs);
            end
            S_FREAD:
            begin
                div_start = !fnum[32];
                div_num   = 64'($unsigned(fnum));
                div_den   = 64'($unsigned(dz_reg));
            end
            S_GND:
            begin
                div_start = gnd_ok;
                div_num   = 64'($unsigned(oz_reg));
                div_den   = 64'($unsigned(gden));
            end
            default:
            begin
                div_start = 1'b0;
                div_num   = '0;
                div_den   = '0;
            end
        endcase
    end

    rnhc_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            busy_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
            widx_reg         <= '0;
            fidx_reg         <= '0;
            mstep_reg        <= '0;
            ox_reg <= '0; oy_reg <= '0; oz_reg <= '0;
            dx_reg <= '0; dy_reg <= '0; dz_reg <= '0;
            cdx_reg <= '0; cdy_reg <= '0;
            ex_reg <= '0; ey_reg <= '0; fx_reg <= '0; fy_reg <= '0; wh_reg <= '0;
            fcx_reg <= '0; fcy_reg <= '0; fhx_reg <= '0; fhy_reg <= '0;
            for (int k = 0; k < 6; k++)
                p_reg[k] <= '0;
            den_reg  <= '0;
            tn_reg   <= '0;
            un_reg   <= '0;
            t_reg    <= '0;
            best_reg <= '0;
            kind_reg <= rnhc_pkg::KIND_NONE;
            mul_reg  <= '0;
            hx_reg   <= '0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            mul_reg          <= mul_prod;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && cmd.opcode == rnhc_pkg::OP_CAST)
                    begin
                        ox_reg   <= cmd.operand_a;
                        oy_reg   <= cmd.operand_b;
                        oz_reg   <= cmd.operand_c;
                        dx_reg   <= cmd.operand_d;
                        dy_reg   <= cmd.operand_e;
                        dz_reg   <= cmd.operand_f;
                        cdx_reg  <= clamp_sym(33'(cmd.operand_d));
                        cdy_reg  <= clamp_sym(33'(cmd.operand_e));
                        best_reg <= max_range_reg;
                        kind_reg <= rnhc_pkg::KIND_NONE;
                        widx_reg <= '0;
                        fidx_reg <= '0;
                        busy_reg <= 1'b1;
                        state_reg <= S_WSEL;
                    end
                end
                S_WSEL:
                begin
                    if (widx_reg == nw)
                        state_reg <= S_FSEL;
                    else
                        state_reg <= S_WREAD;
                end
                S_WREAD:
                begin
                    ex_reg    <= ex_w;
                    ey_reg    <= ey_w;
                    fx_reg    <= fx_w;
                    fy_reg    <= fy_w;
                    wh_reg    <= wall_rd_reg.e;
                    mstep_reg <= '0;
                    state_reg <= S_WMUL;
                end
                S_WMUL:
                begin
                    if (mstep_reg != 3'd0)
                        p_reg[pidx] <= 64'(mul_reg);
                    mstep_reg <= mstep_reg + 3'd1;
                    if (mstep_reg == 3'd6)
                        state_reg <= S_WSUM;
                end
                S_WSUM:
                begin
                    den_reg   <= p_reg[0] - p_reg[1];
                    tn_reg    <= p_reg[2] - p_reg[3];
                    un_reg    <= p_reg[4] - p_reg[5];
                    state_reg <= S_WCHK;
                end
                S_WCHK:
                begin
                    if (wall_reject)
                        state_reg <= S_WNEXT;
                    else
                        state_reg <= S_WDIV;
                end
                S_WDIV:
                begin
                    if (div_done)
                    begin
                        t_reg <= div_quot;
                        if (div_quot < range_lo_reg || div_quot >= best_reg)
                            state_reg <= S_WNEXT;
                        else
                            state_reg <= S_WZMUL;
                    end
                end
                S_WZMUL:
                begin
                    state_reg <= S_WZ;
                end
                S_WZ:
                begin
                    // hit height between ground and wall top (non-positive top: unlimited)
                    if (!zq[65] && !(wh_reg > 32'sd0 && zq > hlim))
                    begin
                        best_reg <= t_reg;
                        kind_reg <= rnhc_pkg::KIND_WALL;
                    end
                    state_reg <= S_WNEXT;
                end
                S_WNEXT:
                begin
                    widx_reg  <= widx_reg + WCW'(1);
                    state_reg <= S_WSEL;
                end
                S_FSEL:
                begin
                    if (dz_reg <= 32'sd0 || fidx_reg == nf)
                        state_reg <= S_GND;
                    else
                        state_reg <= S_FREAD;
                end
                S_FREAD:
                begin
                    fcx_reg <= face_rd_reg.a;
                    fcy_reg <= face_rd_reg.b;
                    fhx_reg <= face_rd_reg.c;
                    fhy_reg <= face_rd_reg.d;
                    if (fnum[32])
                        state_reg <= S_FNEXT;
                    else
                        state_reg <= S_FDIV;
                end
                S_FDIV:
                begin
                    if (div_done)
                    begin
                        t_reg <= div_quot;
                        if (div_quot < range_lo_reg || div_quot >= best_reg)
                            state_reg <= S_FNEXT;
                        else
                            state_reg <= S_FMULX;
                    end
                end
                S_FMULX:
                begin
                    state_reg <= S_FMULY;
                end
                S_FMULY:
                begin
                    hx_reg    <= hx_w;
                    state_reg <= S_FTEST;
                end
                S_FTEST:
                begin
                    if (hx_abs <= hsx_lim && hy_abs <= hsy_lim)
                    begin
                        best_reg <= t_reg;
                        kind_reg <= rnhc_pkg::KIND_FACE;
                    end
                    state_reg <= S_FNEXT;
                end
                S_FNEXT:
                begin
                    fidx_reg  <= fidx_reg + FCW'(1);
                    state_reg <= S_FSEL;
                end
                S_GND:
                begin
                    if (gnd_ok)
                        state_reg <= S_GDIV;
                    else
                        state_reg <= S_DONE;
                end
                S_GDIV:
                begin
                    if (div_done)
                    begin
                        // ground needs strictly more than the near limit
                        if (div_quot > range_lo_reg && div_quot < best_reg)
                        begin
                            best_reg <= div_quot;
                            kind_reg <= rnhc_pkg::KIND_GROUND;
                        end
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    result_reg.hit_distance <= best_reg;
                    result_reg.hit_found    <= best_reg < max_range_reg;
                    result_reg.hit_kind     <= kind_reg;
                    result_valid_reg        <= 1'b1;
                    busy_reg                <= 1'b0;
                    state_reg               <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy         = busy_reg;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTH
    a_result_ends_cast: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (!busy && $past(busy)))
        else $error("result word without a finished cast");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe longer than one cycle");

    a_kind_matches_found: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((result.hit_kind == rnhc_pkg::KIND_NONE) == !result.hit_found))
        else $error("hit kind disagrees with hit flag");

    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_WDIV || state_reg == S_FDIV || state_reg == S_GDIV))
        else $error("divider finished outside a wait state");
`endif

endmodule

// ===== test/rnhc_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rnhc_checker
// Watches the command, config and result channels of the ray caster, keeps
// its own copy of the wall and face tables, predicts every cast and compares
// each result word against the oldest prediction.
// ----------------------------------------------------------------------------
module rnhc_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  rnhc_pkg::cmd_t    cmd,
    input  logic              result_valid,
    input  rnhc_pkg::result_t result,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    output int                fails,
    output int                pending
);

    localparam int     WALLS  = 128;
    localparam int     FACES  = 32;
    localparam longint ONE_Q  = 64'sd65536;
    localparam longint LIM31  = 64'sd2147483647;
    localparam longint unsigned QSAT = 64'h7FFF_FFFF;

    int wall_x1 [WALLS];
    int wall_y1 [WALLS];
    int wall_x2 [WALLS];
    int wall_y2 [WALLS];
    int wall_h  [WALLS];
    int face_cx [FACES];
    int face_cy [FACES];
    int face_hw [FACES];
    int face_hd [FACES];
    int face_h  [FACES];

    logic [7:0]  seg_cnt;
    logic [5:0]  face_cnt;
    logic [30:0] min_rng;
    logic [30:0] max_rng;

    rnhc_pkg::result_t hits_q[$];
    int                mism;

    assign fails = mism;

    function automatic longint clip31(longint v);
        if (v > LIM31)
            return LIM31;
        if (v < -LIM31)
            return -LIM31;
        return v;
    endfunction

    // truncated n/d at 16 fraction bits, saturating at 2^31-1
    function automatic longint unsigned quot(longint unsigned n, longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        if (d == 0)
            return QSAT;
        q = n / d;
        if (q >= 64'd32768)
            return QSAT;
        r = n % d;
        for (int i = 0; i < 16; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= d)
            begin
                r = r - d;
                q = q | 64'd1;
            end
        end
        return (q > QSAT) ? QSAT : q;
    endfunction

    function automatic rnhc_pkg::result_t predict_cast(rnhc_pkg::cmd_t w);
        longint ox, oy, oz, dx, dy, dz, cdx, cdy;
        longint ex, ey, fx, fy, den, tn, un, zq, h, num, hx, hy;
        longint unsigned best, t, lo;
        logic [1:0] kind;
        int nw, nf;
        rnhc_pkg::result_t r;
        ox = longint'(w.operand_a);
        oy = longint'(w.operand_b);
        oz = longint'(w.operand_c);
        dx = longint'(w.operand_d);
        dy = longint'(w.operand_e);
        dz = longint'(w.operand_f);
        cdx = clip31(dx);
        cdy = clip31(dy);
        best = longint'(max_rng);
        lo = longint'(min_rng);
        kind = rnhc_pkg::KIND_NONE;
        nw = (seg_cnt > WALLS) ? WALLS : int'(seg_cnt);
        nf = (face_cnt > FACES) ? FACES : int'(face_cnt);

        for (int i = 0; i < nw; i++)
        begin
            ex = clip31(longint'(wall_x2[i]) - longint'(wall_x1[i]));
            ey = clip31(longint'(wall_y2[i]) - longint'(wall_y1[i]));
            fx = clip31(longint'(wall_x1[i]) - ox);
            fy = clip31(longint'(wall_y1[i]) - oy);
            den = cdx * ey - cdy * ex;
            tn = fx * ey - fy * ex;
            un = fx * cdy - fy * cdx;
            if (den == 0)
                continue;
            if (den < 0)
            begin
                den = -den;
                tn = -tn;
                un = -un;
            end
            if (tn < 0 || un < 0 || un > den)
                continue;
            t = quot(tn, den);
            if (t < lo || t >= best)
                continue;
            zq = oz * ONE_Q + longint'(t) * dz;
            if (zq < 0)
                continue;
            h = longint'(wall_h[i]);
            if (h > 0 && zq > h * ONE_Q)
                continue;
            best = t;
            kind = rnhc_pkg::KIND_WALL;
        end

        if (dz > 0)
        begin
            for (int i = 0; i < nf; i++)
            begin
                num = longint'(face_h[i]) - oz;
                if (num < 0)
                    continue;
                t = quot(num, dz);
                if (t < lo || t >= best)
                    continue;
                hx = (ox - longint'(face_cx[i])) * ONE_Q + longint'(t) * dx;
                hy = (oy - longint'(face_cy[i])) * ONE_Q + longint'(t) * dy;
                if (hx < 0)
                    hx = -hx;
                if (hy < 0)
                    hy = -hy;
                if (hx <= longint'(face_hw[i]) * ONE_Q && hy <= longint'(face_hd[i]) * ONE_Q)
                begin
                    best = t;
                    kind = rnhc_pkg::KIND_FACE;
                end
            end
        end

        // ground needs a distance strictly past the near limit
        if (dz < 0 && oz >= 0)
        begin
            t = quot(oz, -dz);
            if (t > lo && t < best)
            begin
                best = t;
                kind = rnhc_pkg::KIND_GROUND;
            end
        end

        r.hit_distance = best[30:0];
        r.hit_found = (best < longint'(max_rng));
        r.hit_kind = kind;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rnhc_pkg::result_t want;
        if (!rst_n)
        begin
            seg_cnt  = '0;
            face_cnt = '0;
            min_rng  = 31'd26214;
            max_rng  = 31'd9830400;
            mism     = 0;
            hits_q.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    rnhc_pkg::CFG_SEGMENT_COUNT: seg_cnt  = cfg_data[7:0];
                    rnhc_pkg::CFG_FACE_COUNT:    face_cnt = cfg_data[5:0];
                    rnhc_pkg::CFG_MIN_RANGE:     min_rng  = cfg_data[30:0];
                    rnhc_pkg::CFG_MAX_RANGE:     max_rng  = cfg_data[30:0];
                    default: ;
                endcase
            end

            if (start && !busy)
            begin
                case (cmd.opcode)
                    rnhc_pkg::OP_LOAD_WALL:
                    begin
                        wall_x1[cmd.slot] = cmd.operand_a;
                        wall_y1[cmd.slot] = cmd.operand_b;
                        wall_x2[cmd.slot] = cmd.operand_c;
                        wall_y2[cmd.slot] = cmd.operand_d;
                        wall_h[cmd.slot]  = cmd.operand_e;
                    end
                    rnhc_pkg::OP_LOAD_FACE:
                    begin
                        // slots past the face table are dropped
                        if (cmd.slot < FACES)
                        begin
                            face_cx[cmd.slot] = cmd.operand_a;
                            face_cy[cmd.slot] = cmd.operand_b;
                            face_hw[cmd.slot] = cmd.operand_c;
                            face_hd[cmd.slot] = cmd.operand_d;
                            face_h[cmd.slot]  = cmd.operand_e;
                        end
                    end
                    rnhc_pkg::OP_CAST: hits_q = {hits_q, predict_cast(cmd)};
                    default: ;
                endcase
            end

            if (result_valid)
            begin
                if (hits_q.size() == 0)
                begin
                    if (mism < 10)
                        $display("[%0t] unexpected result word: dist %0d found %0d kind %0d",
                                 $realtime, result.hit_distance, result.hit_found,
                                 result.hit_kind);
                    mism++;
                end
                else
                begin
                    want = hits_q.pop_front();
                    if (result.hit_distance !== want.hit_distance
                        || result.hit_found !== want.hit_found
                        || result.hit_kind !== want.hit_kind)
                    begin
                        if (mism < 10)
                            $display("[%0t] mismatch: expected dist %0d found %0d kind %0d, got dist %0d found %0d kind %0d",
                                     $realtime, want.hit_distance, want.hit_found,
                                     want.hit_kind, result.hit_distance,
                                     result.hit_found, result.hit_kind);
                        mism++;
                    end
                end
            end
            pending <= hits_q.size();
        end
    end

endmodule

// ===== test/tb_ray_nearest_hit_caster_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ray_nearest_hit_caster_top
// Drives wall/face loads and ray casts into the caster under several range
// and count settings; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_ray_nearest_hit_caster_top;

    localparam int ONE = 65536;
    localparam int NUM_WORDS = 1300;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    rnhc_pkg::cmd_t    cmd;
    logic              result_valid;
    rnhc_pkg::result_t result;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [1:0]        cfg_index;
    logic [31:0]       cfg_data;
    int                fails;
    int                pending;

    int words_sent;
    int casts_sent;
    int setups;
    int idle_pct;

    ray_nearest_hit_caster_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    rnhc_checker u_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fails        (fails),
        .pending      (pending)
    );

    always #5 clk = ~clk;

    initial
    begin
        #1_000_000_000;
        $display("ray_nearest_hit_caster_top verification failed");
        $finish;
    end

    function automatic int span(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic rnhc_pkg::cmd_t word(logic [1:0] op, logic [6:0] slot, int a, int b,
                                            int c, int d, int e, int f);
        rnhc_pkg::cmd_t w;
        w.opcode = op;
        w.slot = slot;
        w.operand_a = a;
        w.operand_b = b;
        w.operand_c = c;
        w.operand_d = d;
        w.operand_e = e;
        w.operand_f = f;
        return w;
    endfunction

    function automatic rnhc_pkg::cmd_t any_word(logic [1:0] op);
        return word(op, 7'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom);
    endfunction

    function automatic rnhc_pkg::cmd_t wall_word(logic [6:0] slot);
        if ($urandom_range(9) == 0)
            return any_word(rnhc_pkg::OP_LOAD_WALL);
        return word(rnhc_pkg::OP_LOAD_WALL, slot, span(-20 * ONE, 20 * ONE),
                    span(-20 * ONE, 20 * ONE), span(-20 * ONE, 20 * ONE),
                    span(-20 * ONE, 20 * ONE), span(-ONE, 4 * ONE), $urandom);
    endfunction

    function automatic rnhc_pkg::cmd_t face_word(logic [6:0] slot);
        if ($urandom_range(9) == 0)
            return any_word(rnhc_pkg::OP_LOAD_FACE);
        return word(rnhc_pkg::OP_LOAD_FACE, slot, span(-15 * ONE, 15 * ONE),
                    span(-15 * ONE, 15 * ONE), span(-ONE / 2, 3 * ONE),
                    span(-ONE / 2, 3 * ONE), span(0, 3 * ONE), $urandom);
    endfunction

    function automatic rnhc_pkg::cmd_t cast_word();
        int dz;
        if ($urandom_range(9) == 0)
            return any_word(rnhc_pkg::OP_CAST);
        dz = ($urandom_range(4) == 0) ? 0 : span(-ONE / 2, ONE / 2);
        return word(rnhc_pkg::OP_CAST, 7'($urandom), span(-8 * ONE, 8 * ONE),
                    span(-8 * ONE, 8 * ONE), span(-ONE / 2, 3 * ONE), span(-ONE, ONE),
                    span(-ONE, ONE), dz);
    endfunction

    task automatic send(input rnhc_pkg::cmd_t w);
        start <= 1'b1;
        cmd <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (w.opcode != rnhc_pkg::OP_UNUSED)
            words_sent++;
        if (w.opcode == rnhc_pkg::OP_CAST)
            casts_sent++;
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // hold off until every cast has reported and the block is quiet
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_ranges(input logic [30:0] lo, input logic [30:0] hi);
        write_reg(rnhc_pkg::CFG_MIN_RANGE, {1'($urandom), lo});
        write_reg(rnhc_pkg::CFG_MAX_RANGE, {1'($urandom), hi});
    endtask

    initial
    begin
        logic [30:0]    lo;
        logic [30:0]    hi;
        int             seg;
        int             fc;
        int             n_block;
        int             pick;
        rnhc_pkg::cmd_t w;

        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cfg_valid = 1'b0;
        cfg_index = rnhc_pkg::CFG_SEGMENT_COUNT;
        cfg_data = '0;
        words_sent = 0;
        casts_sent = 0;
        setups = 0;
        idle_pct = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: a small scene with known answers
        send(word(rnhc_pkg::OP_LOAD_WALL, 7'd0, 5 * ONE, -5 * ONE, 5 * ONE, 5 * ONE,
                  2 * ONE, 0));
        send(word(rnhc_pkg::OP_LOAD_WALL, 7'd1, 10 * ONE, -5 * ONE, 10 * ONE, 5 * ONE, 0, 0));
        send(word(rnhc_pkg::OP_LOAD_WALL, 7'd2, -10 * ONE, 3 * ONE, 10 * ONE, 3 * ONE,
                  -ONE, 0));
        send(word(rnhc_pkg::OP_LOAD_WALL, 7'd3, -5 * ONE, -5 * ONE, -5 * ONE, 5 * ONE,
                  ONE / 4, 0));
        send(word(rnhc_pkg::OP_LOAD_WALL, 7'd127, 1, 2, 3, 4, 5, 6));
        send(word(rnhc_pkg::OP_LOAD_FACE, 7'd0, 3 * ONE, 0, ONE, ONE, ONE, 0));
        send(word(rnhc_pkg::OP_LOAD_FACE, 7'd1, 3 * ONE, 0, -ONE, ONE, ONE * 4 / 5, 0));
        // face slot past the table, then the unused opcode
        send(word(rnhc_pkg::OP_LOAD_FACE, 7'd40, 0, 0, 50 * ONE, 50 * ONE, ONE, 0));
        send(any_word(rnhc_pkg::OP_UNUSED));
        drain();
        write_reg(rnhc_pkg::CFG_SEGMENT_COUNT, 32'd4);
        write_reg(rnhc_pkg::CFG_FACE_COUNT, 32'd2);
        setups++;
        send(word(rnhc_pkg::OP_CAST, 7'd0, 0, 0, ONE / 2, ONE, 0, 0));
        send(word(rnhc_pkg::OP_CAST, 7'd0, 0, 0, ONE / 2, ONE, 0, ONE / 5));
        send(word(rnhc_pkg::OP_CAST, 7'd0, 0, 0, ONE, ONE, 0, -ONE));
        send(word(rnhc_pkg::OP_CAST, 7'd0, 0, 0, ONE / 2, -ONE, 0, 0));
        send(word(rnhc_pkg::OP_CAST, 7'd0, 0, -4 * ONE, ONE / 2, 0, ONE, 0));
        send(word(rnhc_pkg::OP_CAST, 7'h7F, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send(word(rnhc_pkg::OP_CAST, 7'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send(word(rnhc_pkg::OP_CAST, 7'd0, 0, 0, ONE, 0, 0, 0));
        drain();
        // ground exactly at the near limit misses, a wall exactly there hits
        set_ranges(31'(ONE), 31'(150 * ONE));
        setups++;
        send(word(rnhc_pkg::OP_CAST, 7'd0, 0, 0, ONE, 0, 0, -ONE));
        send(word(rnhc_pkg::OP_CAST, 7'd0, 4 * ONE, 0, ONE / 2, ONE, 0, 0));
        drain();
        set_ranges(31'(2 * ONE), 31'(ONE));
        setups++;
        send(word(rnhc_pkg::OP_CAST, 7'd0, 0, 0, ONE / 2, ONE, 0, 0));
        send(word(rnhc_pkg::OP_CAST, 7'd0, 0, 0, ONE, ONE / 2, 0, -ONE));
        drain();

        // fill both tables so any count can be cast against
        idle_pct = 38;
        for (int i = 0; i < 128; i++)
        begin
            w = wall_word(7'(i));
            w.slot = 7'(i);
            send(w);
        end
        for (int i = 0; i < 32; i++)
        begin
            w = face_word(7'(i));
            w.slot = 7'(i);
            send(w);
        end
        drain();

        while (words_sent < NUM_WORDS)
        begin
            pick = $urandom_range(9);
            seg = (pick == 0) ? 0 : (pick == 1) ? (($urandom_range(1)) ? 128 : 200)
                                                : span(1, 12);
            pick = $urandom_range(9);
            fc = (pick == 0) ? 0 : (pick == 1) ? (($urandom_range(1)) ? 32 : 63)
                                               : span(1, 8);
            pick = $urandom_range(9);
            lo = (pick == 0) ? 31'd0 : (pick == 1) ? 31'h7FFF_FFFF : 31'(span(0, ONE));
            pick = $urandom_range(9);
            hi = (pick == 0) ? 31'h7FFF_FFFF : (pick == 1) ? 31'(span(0, 2 * ONE))
                                                           : 31'(span(5 * ONE, 150 * ONE));
            write_reg(rnhc_pkg::CFG_SEGMENT_COUNT, {24'($urandom), 8'(seg)});
            write_reg(rnhc_pkg::CFG_FACE_COUNT, {26'($urandom), 6'(fc)});
            set_ranges(lo, hi);
            setups++;

            n_block = (seg >= 128) ? 10 : 40;
            for (int k = 0; k < n_block; k++)
            begin
                if (words_sent < NUM_WORDS / 3)
                    idle_pct = 38;
                else if (words_sent < 2 * NUM_WORDS / 3)
                    idle_pct = 46;
                else
                    idle_pct = 0;
                pick = $urandom_range(99);
                if (pick < 55)
                    w = cast_word();
                else if (pick < 77)
                    w = wall_word(7'($urandom));
                else if (pick < 97)
                    w = face_word(7'($urandom));
                else
                    w = any_word(rnhc_pkg::OP_UNUSED);
                send(w);
            end
            drain();
        end

        drain();
        $display("ran %0d command words, %0d of them casts, over %0d register settings",
                 words_sent, casts_sent, setups);
        if (fails == 0 && pending == 0)
            $display("ray_nearest_hit_caster_top verification clean");
        else
            $display("ray_nearest_hit_caster_top verification failed");
        $finish;
    end

endmodule

// ===== ray_nearest_hit_caster_top.f =====
sv/rnhc_pkg.sv
sv/rnhc_div.sv
sv/ray_nearest_hit_caster_top.sv
test/rnhc_checker.sv
test/tb_ray_nearest_hit_caster_top.sv
